// ===== rtl/robin_hood_hash_table_core_defines.svh =====
// Assertion macros for the file that checks its own logic.
`ifndef ROBIN_HOOD_HASH_TABLE_CORE_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_CORE_DEFINES_SVH

// A condition that must bring a consequence in the same cycle.
`define RHH_ASSERT_IMPL(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("rhh check failed");

// A condition that must bring a consequence in the following cycle.
`define RHH_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("rhh check failed");

`endif

// ===== rtl/rhh_pkg.sv =====
package rhh_pkg;

  // Table geometry. Slot 0 is never used, so at most CAPACITY-1 entries live.
  localparam int CAPACITY   = 1024;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_PROBES = 128;
  localparam int LOG_W      = $clog2(MAX_PROBES);
  localparam int NLOG_W     = LOG_W + 1;

  // Hash finalizer constants.
  localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT = 33;

  // Operation codes.
  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_GET    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  // One table slot; a home of zero means the slot was never used.
  typedef struct packed {
    logic [63:0]      key;
    logic [63:0]      value;
    logic [IDX_W-1:0] home;
    logic             deleted;
  } slot_t;

  // One undo record: where a slot was written and what it held before.
  typedef struct packed {
    logic [IDX_W-1:0] pos;
    slot_t            old;
  } undo_t;

  // Probe step: wrap from the top back to slot 1, skipping slot 0.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] n;
    n = p + 1'b1;
    return (n == '0) ? {{(IDX_W-1){1'b0}}, 1'b1} : n;
  endfunction

endpackage

// ===== rtl/rhh_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rhh_hash.sv =====
// Home slot from the 64-bit finalizer. Each 64x64 low product is built from
// three 32x32 partial products on one shared multiplier, then folded and xor-shifted.
module rhh_hash (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [63:0]             key,
  output logic                    done,
  output logic [rhh_pkg::IDX_W-1:0] home
);

  logic        busy;
  logic [1:0]  ph;
  logic        rnd;
  logic [63:0] x;
  logic [63:0] p0;
  logic [31:0] p1;
  logic [31:0] p2;
  logic [63:0] cst;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] y;
  logic [63:0] mixed;
  logic [rhh_pkg::IDX_W-1:0] hraw;

  // Operand selection for the shared multiplier.
  always_comb begin
    cst   = rnd ? rhh_pkg::MIX_C2 : rhh_pkg::MIX_C1;
    mul_a = (ph == 2'd2) ? x[63:32] : x[31:0];
    mul_b = (ph == 2'd1) ? cst[63:32] : cst[31:0];
    prod  = mul_a * mul_b;
    y     = p0 + {p1 + p2, 32'b0};
    mixed = y ^ (y >> rhh_pkg::MIX_SHIFT);
    hraw  = x[rhh_pkg::IDX_W-1:0];
    home  = (hraw == '0) ? {{(rhh_pkg::IDX_W-1){1'b0}}, 1'b1} : hraw;
  end

  // Round sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      ph   <= '0;
      rnd  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ph   <= '0;
        rnd  <= 1'b0;
      end else if (busy) begin
        ph <= ph + 1'b1;
        if (ph == 2'd3) begin
          if (rnd) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            rnd <= 1'b1;
          end
        end
      end
    end
  end

  // Datapath: partial products, then the fold and xor-shift.
  always_ff @(posedge clk) begin
    if (start) begin
      x <= key ^ (key >> rhh_pkg::MIX_SHIFT);
    end else if (busy) begin
      unique case (ph)
        2'd0: p0 <= prod;
        2'd1: p1 <= prod[31:0];
        2'd2: p2 <= prod[31:0];
        2'd3: x  <= mixed;
        default: x <= x;
      endcase
    end
  end

endmodule

// ===== rtl/robin_hood_hash_table_core.sv =====
// Robin Hood open-addressing map, 64-bit keys to 64-bit values, 1023 usable
// slots held in one synchronous table memory plus a 128-entry undo memory.
// After reset a clearing pass writes every slot, one per cycle, before the
// first request is accepted. A request first hashes the key, then probes
// slot by slot, then posts the result; the probe loop reads the next slot
// while writing the current one, so the table port sets one probe a cycle.
// An insert that fails after 128 probes replays the undo memory backward,
// restoring one slot for each swap it made. Function 3 answers with status 1.
// One request is worked at a time; a new one is taken while the previous
// result still waits on the output register.
`include "robin_hood_hash_table_core_defines.svh"

module robin_hood_hash_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [127:0]  s_tdata,   // key [63:0], value [127:64]
  input  logic [1:0]    s_tuser,   // func [1:0]
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [79:0]   m_tdata,   // read_value [63:0], item_count [74:64], zero [79:75]
  output logic [1:0]    m_tuser    // status [1:0]
);

  localparam int IDX_W  = rhh_pkg::IDX_W;
  localparam int CNT_W  = rhh_pkg::CNT_W;
  localparam int LOG_W  = rhh_pkg::LOG_W;
  localparam int NLOG_W = rhh_pkg::NLOG_W;

  typedef enum logic [7:0] {
    S_CLEAR   = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_HASH    = 8'b0000_0100,
    S_PROBE   = 8'b0000_1000,
    S_UNDO_RD = 8'b0001_0000,
    S_UNDO_WR = 8'b0010_0000,
    S_DONE    = 8'b0100_0000
  } state_t;

  state_t state;

  logic [IDX_W-1:0]  clr_idx;
  logic [1:0]        fn;
  logic [63:0]       key_r;
  logic [63:0]       val_r;
  logic [IDX_W-1:0]  hk;
  logic [63:0]       ck;
  logic [63:0]       cv;
  logic [IDX_W-1:0]  ch;
  logic [IDX_W-1:0]  p;
  logic [CNT_W-1:0]  disp;
  logic [IDX_W-1:0]  n;
  logic [NLOG_W-1:0] nlog;
  logic [CNT_W-1:0]  live_count;
  logic [1:0]        res_status;
  logic [63:0]       res_value;
  logic [63:0]       out_value;
  logic [CNT_W-1:0]  out_count;
  logic [1:0]        out_status;

  logic              accept;
  logic              hash_start;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_home;
  logic              post;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  rhh_pkg::slot_t    tbl_wdata;
  logic [IDX_W-1:0]  tbl_raddr;
  rhh_pkg::slot_t    tbl_rdata;
  logic              log_we;
  rhh_pkg::undo_t    log_wdata;
  logic [LOG_W-1:0]  log_raddr;
  rhh_pkg::undo_t    log_rdata;

  rhh_pkg::slot_t    e;
  logic [IDX_W-1:0]  pn;
  logic [IDX_W-1:0]  ed;
  logic [IDX_W-1:0]  d;
  logic              is_ins;
  logic              live;
  logic              empty;
  logic              steal;
  logic              ins_hit;
  logic              ins_place;
  logic              ins_swap;
  logic              ins_last;
  logic              fnd_hit;
  logic              fnd_stop;
  logic              fnd_last;
  logic [NLOG_W-1:0] nlog_after;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign hash_start = accept && (s_tuser != rhh_pkg::FN_NONE);
  assign post     = (state == S_DONE) && (!m_tvalid || m_tready);

  assign m_tdata = {5'b0, out_count, out_value};
  assign m_tuser = out_status;

  rhh_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (s_tdata[63:0]),
    .done  (hash_done),
    .home  (hash_home)
  );

  rhh_ram #(.WIDTH($bits(rhh_pkg::slot_t)), .DEPTH(rhh_pkg::CAPACITY)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  rhh_ram #(.WIDTH($bits(rhh_pkg::undo_t)), .DEPTH(rhh_pkg::MAX_PROBES)) u_undo (
    .clk   (clk),
    .we    (log_we),
    .waddr (nlog[LOG_W-1:0]),
    .wdata (log_wdata),
    .raddr (log_raddr),
    .rdata (log_rdata)
  );

  // Probe decisions on the slot read last cycle.
  always_comb begin
    e         = tbl_rdata;
    pn        = rhh_pkg::next_slot(p);
    ed        = p - e.home;
    d         = pn - e.home;
    is_ins    = (fn == rhh_pkg::FN_INSERT);
    live      = (e.home != '0) && !e.deleted;
    empty     = (e.home == '0);
    steal     = ({1'b0, ed} < disp);
    ins_hit   = live && (e.key == ck);
    ins_place = ins_hit || empty || (steal && e.deleted);
    ins_swap  = !ins_place && steal;
    ins_last  = (n == IDX_W'(rhh_pkg::MAX_PROBES - 1));
    fnd_hit   = live && (e.home == hk) && (e.key == key_r);
    fnd_stop  = empty || ((d != '0) && (disp >= {1'b0, d}));
    fnd_last  = (n == '1);
    nlog_after = nlog + NLOG_W'(ins_swap);
  end

  // Memory port control.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = p;
    tbl_wdata = '0;
    tbl_raddr = p;
    log_we    = 1'b0;
    log_wdata = '{pos: p, old: e};
    log_raddr = LOG_W'(nlog - 1'b1);
    unique case (state)
      S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_idx;
      end
      S_HASH: begin
        tbl_raddr = hash_home;
      end
      S_PROBE: begin
        tbl_raddr = pn;
        if (is_ins) begin
          if (ins_place || ins_swap) begin
            tbl_we    = 1'b1;
            tbl_wdata = '{key: ck, value: cv, home: ch, deleted: 1'b0};
            log_we    = 1'b1;
          end
        end else if (fnd_hit && (fn == rhh_pkg::FN_REMOVE)) begin
          tbl_we    = 1'b1;
          tbl_wdata = '{key: 64'd0, value: 64'd0, home: e.home, deleted: 1'b1};
        end
      end
      S_UNDO_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = log_rdata.pos;
        tbl_wdata = log_rdata.old;
      end
      default: begin
        tbl_we = 1'b0;
      end
    endcase
  end

  // Control sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      live_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (post) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= (s_tuser == rhh_pkg::FN_NONE) ? S_DONE : S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (is_ins) begin
            if (ins_place) begin
              if (!ins_hit) begin
                live_count <= live_count + 1'b1;
              end
              state <= S_DONE;
            end else if (ins_last) begin
              state <= (nlog_after != '0) ? S_UNDO_RD : S_DONE;
            end
          end else if (fnd_hit) begin
            if ((fn == rhh_pkg::FN_REMOVE) && (live_count != '0)) begin
              live_count <= live_count - 1'b1;
            end
            state <= S_DONE;
          end else if (fnd_stop || fnd_last) begin
            state <= S_DONE;
          end
        end
        S_UNDO_RD: begin
          state <= S_UNDO_WR;
        end
        S_UNDO_WR: begin
          state <= (nlog == '0) ? S_DONE : S_UNDO_RD;
        end
        S_DONE: begin
          if (post) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request datapath and probe bookkeeping.
  always_ff @(posedge clk) begin
    if (accept) begin
      fn         <= s_tuser;
      key_r      <= s_tdata[63:0];
      val_r      <= s_tdata[127:64];
      res_status <= rhh_pkg::STS_MISS;
      res_value  <= '0;
    end
    if ((state == S_HASH) && hash_done) begin
      p    <= hash_home;
      hk   <= hash_home;
      ch   <= hash_home;
      ck   <= key_r;
      cv   <= val_r;
      disp <= '0;
      n    <= '0;
      nlog <= '0;
    end
    if (state == S_PROBE) begin
      p <= pn;
      n <= n + 1'b1;
      if (is_ins) begin
        if (ins_place) begin
          res_status <= rhh_pkg::STS_OK;
        end else begin
          if (ins_swap) begin
            ck   <= e.key;
            cv   <= e.value;
            ch   <= e.home;
            disp <= CNT_W'(ed) + 1'b1;
            nlog <= nlog_after;
          end else begin
            disp <= disp + 1'b1;
          end
          if (ins_last) begin
            res_status <= rhh_pkg::STS_FULL;
          end
        end
      end else if (fnd_hit) begin
        res_status <= rhh_pkg::STS_OK;
        if (fn == rhh_pkg::FN_GET) begin
          res_value <= e.value;
        end
      end else begin
        disp <= disp + 1'b1;
      end
    end
    if (state == S_UNDO_RD) begin
      nlog <= nlog - 1'b1;
    end
    if (post) begin
      out_status <= res_status;
      out_value  <= res_value;
      out_count  <= live_count;
    end
  end

  // No request is taken while the table is being cleared.
  `RHH_ASSERT_IMPL(a_no_accept_in_clear, state == S_CLEAR, !s_tready)
  // A probe never writes the slot it is reading for the next step.
  `RHH_ASSERT_IMPL(a_probe_no_overlap, (state == S_PROBE) && tbl_we, tbl_waddr != tbl_raddr)
  // The live count never exceeds the number of usable slots.
  `RHH_ASSERT_IMPL(a_count_bound, 1'b1, live_count <= CNT_W'(rhh_pkg::CAPACITY - 1))
  // One request at a time: acceptance closes the input until the result is posted.
  `RHH_ASSERT_NEXT(a_one_at_a_time, accept, !s_tready)

endmodule

// ===== dv/robin_hood_hash_table_core_tb.sv =====
`timescale 1ns / 1ps

module robin_hood_hash_table_core_tb;

  // Expected response of one request.
  typedef struct {
    logic [1:0]                status;
    logic [63:0]               read_value;
    logic [rhh_pkg::CNT_W-1:0] item_count;
  } response_t;

  // Shadow copy of the map; predicts each response from the requests taken.
  class hash_map_tracker;
    logic [63:0]               keys[rhh_pkg::CAPACITY];
    logic [63:0]               values[rhh_pkg::CAPACITY];
    logic [rhh_pkg::IDX_W-1:0] homes[rhh_pkg::CAPACITY];
    logic                      tombs[rhh_pkg::CAPACITY];
    logic [rhh_pkg::CNT_W-1:0] live;
    rhh_pkg::slot_t            undo_slots[$];
    int                        undo_pos[$];
    response_t                 pending[$];
    int                        errors;
    int                        n_checked, n_full, n_found, n_removed;

    function new();
      for (int i = 0; i < rhh_pkg::CAPACITY; i++) begin
        keys[i] = '0;
        values[i] = '0;
        homes[i] = '0;
        tombs[i] = 1'b0;
      end
      live = '0;
      errors = 0;
      n_checked = 0;
      n_full = 0;
      n_found = 0;
      n_removed = 0;
    endfunction

    function logic [rhh_pkg::IDX_W-1:0] home_of(logic [63:0] k);
      logic [63:0] m;
      m = k ^ (k >> rhh_pkg::MIX_SHIFT);
      m = m * rhh_pkg::MIX_C1;
      m = m ^ (m >> rhh_pkg::MIX_SHIFT);
      m = m * rhh_pkg::MIX_C2;
      m = m ^ (m >> rhh_pkg::MIX_SHIFT);
      return (m[rhh_pkg::IDX_W-1:0] == '0) ? rhh_pkg::IDX_W'(1) : m[rhh_pkg::IDX_W-1:0];
    endfunction

    function logic [rhh_pkg::IDX_W-1:0] step(logic [rhh_pkg::IDX_W-1:0] p);
      logic [rhh_pkg::IDX_W-1:0] n;
      n = p + 1'b1;
      return (n == '0) ? rhh_pkg::IDX_W'(1) : n;
    endfunction

    function logic is_live(int p);
      return homes[p] != '0 && !tombs[p];
    endfunction

    // Returns the slot holding the key, or 0 when it is absent.
    function int locate(logic [63:0] k);
      logic [rhh_pkg::IDX_W-1:0] h, p, cur, d;
      logic [63:0] disp;
      h = home_of(k);
      p = h;
      disp = 0;
      for (int n = 0; n < rhh_pkg::CAPACITY; n++) begin
        cur = p;
        if (is_live(cur) && homes[cur] == h && keys[cur] == k) return cur;
        p = step(p);
        if (homes[cur] == '0) return 0;
        d = p - homes[cur];
        // A displacement of zero wraps to the largest bound and never stops.
        if (!(disp <= {54'd0, d} - 64'd1)) return 0;
        disp++;
      end
      return 0;
    endfunction

    function void put(int p, logic [63:0] k, logic [63:0] v,
                      logic [rhh_pkg::IDX_W-1:0] h);
      rhh_pkg::slot_t s;
      if (undo_pos.size() < rhh_pkg::MAX_PROBES) begin
        s.key = keys[p];
        s.value = values[p];
        s.home = homes[p];
        s.deleted = tombs[p];
        undo_slots.push_back(s);
        undo_pos.push_back(p);
      end
      keys[p] = k;
      values[p] = v;
      homes[p] = h;
      tombs[p] = 1'b0;
    endfunction

    function logic [1:0] insert(logic [63:0] k, logic [63:0] v);
      logic [63:0] ck, cv, tk, tv;
      logic [rhh_pkg::IDX_W-1:0] ch, th, p, ed;
      logic [63:0] disp;
      logic [rhh_pkg::CNT_W-1:0] saved;
      rhh_pkg::slot_t s;
      int q;
      ck = k;
      cv = v;
      ch = home_of(k);
      p = ch;
      disp = 0;
      saved = live;
      undo_slots.delete();
      undo_pos.delete();
      for (int n = 0; n < rhh_pkg::MAX_PROBES; n++) begin
        if (is_live(p) && keys[p] == ck) begin
          put(p, ck, cv, ch);
          return rhh_pkg::STS_OK;
        end
        if (homes[p] == '0) begin
          live++;
          put(p, ck, cv, ch);
          return rhh_pkg::STS_OK;
        end
        ed = p - homes[p];
        if ({54'd0, ed} < disp) begin
          if (tombs[p]) begin
            live++;
            put(p, ck, cv, ch);
            return rhh_pkg::STS_OK;
          end
          // Take the slot from the less displaced occupant and carry it on.
          tk = keys[p];
          tv = values[p];
          th = homes[p];
          put(p, ck, cv, ch);
          ck = tk;
          cv = tv;
          ch = th;
          disp = {54'd0, ed};
        end
        p = step(p);
        disp++;
      end
      // Probe budget spent: roll back every swap, newest first.
      while (undo_pos.size() > 0) begin
        s = undo_slots.pop_back();
        q = undo_pos.pop_back();
        keys[q] = s.key;
        values[q] = s.value;
        homes[q] = s.home;
        tombs[q] = s.deleted;
      end
      live = saved;
      return rhh_pkg::STS_FULL;
    endfunction

    function void take_request(logic [1:0] fn, logic [63:0] k, logic [63:0] v);
      response_t r;
      int p;
      r.status = rhh_pkg::STS_MISS;
      r.read_value = '0;
      case (fn)
        rhh_pkg::FN_INSERT: begin
          r.status = insert(k, v);
          if (r.status == rhh_pkg::STS_FULL) n_full++;
        end
        rhh_pkg::FN_GET: begin
          p = locate(k);
          if (p != 0) begin
            r.status = rhh_pkg::STS_OK;
            r.read_value = values[p];
            n_found++;
          end
        end
        rhh_pkg::FN_REMOVE: begin
          p = locate(k);
          if (p != 0) begin
            tombs[p] = 1'b1;
            keys[p] = '0;
            values[p] = '0;
            if (live != 0) live--;
            r.status = rhh_pkg::STS_OK;
            n_removed++;
          end
        end
        default: ;
      endcase
      r.item_count = live;
      pending.push_back(r);
    endfunction

    function void check_response(logic [1:0] st, logic [63:0] rv,
                                 logic [rhh_pkg::CNT_W-1:0] cnt, logic [4:0] pad);
      response_t e;
      if (pending.size() == 0) begin
        $error("response with none outstanding: status %0d", st);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (rv !== e.read_value) begin
        $error("read_value: expected %h, actual %h", e.read_value, rv);
        errors++;
      end
      if (cnt !== e.item_count) begin
        $error("item_count: expected %0d, actual %0d", e.item_count, cnt);
        errors++;
      end
      if (pad !== 5'd0) begin
        $error("tdata padding: expected 0, actual %h", pad);
        errors++;
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [127:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;
  logic [1:0]   m_tuser;

  hash_map_tracker tracker;
  logic [63:0]     known_keys[$];
  bit              steady;
  int              n_sent;

  robin_hood_hash_table_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock generation.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Result side backpressure, off during the steady stretch.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 29);
    end
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      tracker.take_request(s_tuser, s_tdata[63:0], s_tdata[127:64]);
    end
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_response(m_tuser, m_tdata[63:0], m_tdata[74:64], m_tdata[79:75]);
    end
  end

  // Presents one request and holds it until it is taken.
  task automatic send(input logic [1:0] fn, input logic [63:0] k, input logic [63:0] v);
    while (!steady && $urandom_range(99) < 29) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = fn;
    s_tdata = {v, k};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
    n_sent++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    if (known_keys.size() == 0 || $urandom_range(99) < 20) return rand64();
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  // One random request; ins_pct sets how often it is an insert of a new key.
  task automatic random_request(input int ins_pct);
    int r;
    logic [63:0] k;
    r = $urandom_range(99);
    if (r < ins_pct) begin
      k = rand64();
      known_keys.push_back(k);
      send(rhh_pkg::FN_INSERT, k, rand64());
    end else if (r < ins_pct + 10) begin
      send(rhh_pkg::FN_INSERT, pick_key(), rand64());
    end else if (r < ins_pct + 45) begin
      send(rhh_pkg::FN_GET, pick_key(), rand64());
    end else if (r < 96) begin
      send(rhh_pkg::FN_REMOVE, pick_key(), rand64());
    end else begin
      send(rhh_pkg::FN_NONE, pick_key(), rand64());
    end
  endtask

  task automatic drain();
    while (tracker.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    tracker = new();
    steady = 1'b0;
    n_sent = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rhh_pkg::FN_INSERT;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed: empty-table cases, extreme keys and values, updates, tombstones.
    send(rhh_pkg::FN_REMOVE, 64'd0, 64'd0);
    send(rhh_pkg::FN_GET, 64'd0, '1);
    send(rhh_pkg::FN_NONE, '1, '1);
    send(rhh_pkg::FN_INSERT, 64'd0, '1);
    send(rhh_pkg::FN_INSERT, '1, 64'd0);
    send(rhh_pkg::FN_GET, 64'd0, 64'd0);
    send(rhh_pkg::FN_GET, '1, 64'd0);
    send(rhh_pkg::FN_INSERT, 64'd0, 64'h5555_aaaa_5555_aaaa);
    send(rhh_pkg::FN_GET, 64'd0, 64'd0);
    send(rhh_pkg::FN_REMOVE, '1, 64'd0);
    send(rhh_pkg::FN_GET, '1, 64'd0);
    send(rhh_pkg::FN_REMOVE, '1, 64'd0);
    send(rhh_pkg::FN_INSERT, '1, 64'h8000_0000_0000_0001);
    send(rhh_pkg::FN_GET, '1, 64'd0);
    send(rhh_pkg::FN_NONE, 64'd0, 64'd0);
    send(rhh_pkg::FN_REMOVE, 64'd0, 64'd0);
    send(rhh_pkg::FN_REMOVE, '1, 64'd0);
    send(rhh_pkg::FN_REMOVE, 64'd0, 64'd0);
    send(rhh_pkg::FN_INSERT, 64'h8000_0000_0000_0000, 64'h0000_0000_ffff_ffff);
    send(rhh_pkg::FN_GET, 64'h8000_0000_0000_0000, 64'd0);

    // Mixed traffic on a growing key set.
    for (int i = 0; i < 600; i++) begin
      steady = (i >= 200 && i < 400);
      random_request(35);
    end
    steady = 1'b0;

    // Hold off until every response is back.
    drain();

    // Fill toward capacity so long clusters and failed inserts appear.
    for (int i = 0; i < 1000; i++) random_request(60);

    drain();
    repeat (64) @(posedge clk);
    $display("Covered %0d requests: %0d hits, %0d removes, %0d failed inserts.",
             n_sent, tracker.n_found, tracker.n_removed, tracker.n_full);
    $display("Final live count %0d, %0d responses checked.", tracker.live,
             tracker.n_checked);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
